@@ hw/rtl/rtei_pkg.sv @@
// ----------------------------------------------------------------------------
// rtei_pkg
// Shared types and codes for the ray / triangle-edge crossing block.
// ----------------------------------------------------------------------------
package rtei_pkg;

    localparam int IDX_W   = 10;   // vertex index field width
    localparam int CRD_W   = 32;   // coordinate field width on the ports
    localparam int EDGE_W  = 2;    // edge number width
    localparam int PARAM_W = 17;   // unsigned Q1.16 t, range 1..65536
    localparam int FRAC_W  = 16;   // fraction bits of Q1.16

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [EDGE_W-1:0] EDGE_AB = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_BC = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_CA = 2'd2;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        load_index;
        logic signed [CRD_W-1:0] load_x;
        logic signed [CRD_W-1:0] load_y;
        logic [IDX_W-1:0]        corner_first;
        logic [IDX_W-1:0]        corner_second;
        logic [IDX_W-1:0]        corner_third;
        logic signed [CRD_W-1:0] start_x;
        logic signed [CRD_W-1:0] start_y;
        logic signed [CRD_W-1:0] dir_x;
        logic signed [CRD_W-1:0] dir_y;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   edge_vertex_a;
        logic [IDX_W-1:0]   edge_vertex_b;
        logic [EDGE_W-1:0]  edge_number;
        logic [PARAM_W-1:0] hit_param;
    } result_t;

endpackage

@@ hw/rtl/ray_triangle_edge_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_edge_intersect
// Vertex store plus a fully pipelined ray versus triangle-edge crossing test.
// ----------------------------------------------------------------------------
// A command item is taken at every rising edge where start is high; busy is
// always low, so one item may enter in every cycle. A load item writes one
// vertex into the store and gives no result. A query item gives exactly one
// result, shown on result for one cycle with result_valid high, after it
// has passed through the pipeline (store read, edge vectors, products,
// cross sums, sign normalize, range test and edge select, then a 17-stage
// restoring divider that forms t one quotient bit per stage, and the output
// register). The receiver cannot hold results off and need not: results
// leave in item order at the same rate items enter. A query sees every load
// taken before it. The store keeps three copies, one read port per corner,
// so all three corners are fetched in the same cycle; its contents are undefined
// until written. Edges are tried in the order first-second, second-third,
// third-first; the first with t and s both in [2^-16, 1] wins, with t given
// as floor(65536 * t). A zero denominator skips that edge. On a miss all
// result fields read zero. An index at or beyond VERTEX_DEPTH is ignored on
// a load and reads as the origin in a query.
// ----------------------------------------------------------------------------
module ray_triangle_edge_intersect #(
    parameter int VERTEX_DEPTH = 1024,
    parameter int COORD_WIDTH  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rtei_pkg::cmd_t   cmd,
    output logic             result_valid,
    output rtei_pkg::result_t result
);
    import rtei_pkg::*;

    localparam int AW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int PW   = 2 * DW;          // product
    localparam int XW   = PW + 1;          // cross sum
    localparam int SW   = XW + FRAC_W;     // cross sum scaled by 2^16
    localparam int RW   = XW + 1;          // divider remainder
    localparam int NSTP = PARAM_W;         // divider steps

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  va;
        logic [IDX_W-1:0]  vb;
        logic [EDGE_W-1:0] num;
    } meta_t;

    // ------------------------------------------------------------------------
    // Stage 0: accept, store write, store read
    // ------------------------------------------------------------------------
    logic accept;
    logic load_ok;
    logic [31:0] load_ext;
    logic [31:0] corner_ext [3];
    logic [AW-1:0] corner_addr [3];
    logic [AW-1:0] load_addr;
    logic [IDX_W-1:0] corner_idx [3];

    logic [2*CW-1:0] mem_0 [VERTEX_DEPTH];
    logic [2*CW-1:0] mem_1 [VERTEX_DEPTH];
    logic [2*CW-1:0] mem_2 [VERTEX_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign corner_idx[0] = cmd.corner_first;
    assign corner_idx[1] = cmd.corner_second;
    assign corner_idx[2] = cmd.corner_third;

    always_comb
    begin
        load_ext  = 32'(cmd.load_index);
        load_addr = load_ext[AW-1:0];
        load_ok   = accept && (cmd.action == ACT_LOAD) && (load_ext < 32'(VERTEX_DEPTH));
        for (int k = 0; k < 3; k++)
        begin
            corner_ext[k]  = 32'(corner_idx[k]);
            corner_addr[k] = corner_ext[k][AW-1:0];
        end
    end

    logic [2*CW-1:0]       rd_reg [3];
    logic                  s1_valid_reg;
    logic                  s1_inr_reg [3];
    logic [IDX_W-1:0]      s1_idx_reg [3];
    logic signed [CW-1:0]  s1_px_reg, s1_py_reg, s1_dx_reg, s1_dy_reg;

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            mem_0[load_addr] <= {cmd.load_y[CW-1:0], cmd.load_x[CW-1:0]};
            mem_1[load_addr] <= {cmd.load_y[CW-1:0], cmd.load_x[CW-1:0]};
            mem_2[load_addr] <= {cmd.load_y[CW-1:0], cmd.load_x[CW-1:0]};
        end
        rd_reg[0] <= mem_0[corner_addr[0]];
        rd_reg[1] <= mem_1[corner_addr[1]];
        rd_reg[2] <= mem_2[corner_addr[2]];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_inr_reg[k] <= corner_ext[k] < 32'(VERTEX_DEPTH);
            s1_idx_reg[k] <= corner_idx[k];
        end
        s1_px_reg <= cmd.start_x[CW-1:0];
        s1_py_reg <= cmd.start_y[CW-1:0];
        s1_dx_reg <= cmd.dir_x[CW-1:0];
        s1_dy_reg <= cmd.dir_y[CW-1:0];
    end

    // ------------------------------------------------------------------------
    // Stage 1: edge vectors e = b - a and offsets w = a - p
    // ------------------------------------------------------------------------
    logic signed [DW-1:0] vx [3];
    logic signed [DW-1:0] vy [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (s1_inr_reg[k])
            begin
                vx[k] = DW'($signed(rd_reg[k][CW-1:0]));
                vy[k] = DW'($signed(rd_reg[k][2*CW-1:CW]));
            end
            else
            begin
                vx[k] = '0;
                vy[k] = '0;
            end
        end
    end

    logic                  s2_valid_reg;
    logic [IDX_W-1:0]      s2_idx_reg [3];
    logic signed [DW-1:0]  s2_ex_reg [3];
    logic signed [DW-1:0]  s2_ey_reg [3];
    logic signed [DW-1:0]  s2_wx_reg [3];
    logic signed [DW-1:0]  s2_wy_reg [3];
    logic signed [DW-1:0]  s2_dx_reg, s2_dy_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_idx_reg[k] <= s1_idx_reg[k];
            s2_ex_reg[k]  <= vx[(k + 1) % 3] - vx[k];
            s2_ey_reg[k]  <= vy[(k + 1) % 3] - vy[k];
            s2_wx_reg[k]  <= vx[k] - DW'(s1_px_reg);
            s2_wy_reg[k]  <= vy[k] - DW'(s1_py_reg);
        end
        s2_dx_reg <= DW'(s1_dx_reg);
        s2_dy_reg <= DW'(s1_dy_reg);
    end

    // ------------------------------------------------------------------------
    // Stage 2: the six products of each edge
    // ------------------------------------------------------------------------
    logic                  s3_valid_reg;
    logic [IDX_W-1:0]      s3_idx_reg [3];
    logic signed [PW-1:0]  s3_dey_reg [3], s3_dyex_reg [3];
    logic signed [PW-1:0]  s3_wxey_reg [3], s3_wyex_reg [3];
    logic signed [PW-1:0]  s3_wxdy_reg [3], s3_wydx_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_idx_reg[k]  <= s2_idx_reg[k];
            s3_dey_reg[k]  <= s2_dx_reg * s2_ey_reg[k];
            s3_dyex_reg[k] <= s2_dy_reg * s2_ex_reg[k];
            s3_wxey_reg[k] <= s2_wx_reg[k] * s2_ey_reg[k];
            s3_wyex_reg[k] <= s2_wy_reg[k] * s2_ex_reg[k];
            s3_wxdy_reg[k] <= s2_wx_reg[k] * s2_dy_reg;
            s3_wydx_reg[k] <= s2_wy_reg[k] * s2_dx_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: cross sums D, Nt, Ns
    // ------------------------------------------------------------------------
    logic                  s4_valid_reg;
    logic [IDX_W-1:0]      s4_idx_reg [3];
    logic signed [XW-1:0]  s4_den_reg [3], s4_nt_reg [3], s4_ns_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s4_idx_reg[k] <= s3_idx_reg[k];
            s4_den_reg[k] <= XW'(s3_dey_reg[k]) - XW'(s3_dyex_reg[k]);
            s4_nt_reg[k]  <= XW'(s3_wxey_reg[k]) - XW'(s3_wyex_reg[k]);
            s4_ns_reg[k]  <= XW'(s3_wxdy_reg[k]) - XW'(s3_wydx_reg[k]);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: make D positive, flag zero denominators
    // ------------------------------------------------------------------------
    logic                  s5_valid_reg;
    logic [IDX_W-1:0]      s5_idx_reg [3];
    logic                  s5_nz_reg [3];
    logic signed [XW-1:0]  s5_den_reg [3], s5_nt_reg [3], s5_ns_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s5_idx_reg[k] <= s4_idx_reg[k];
            s5_nz_reg[k]  <= s4_den_reg[k] != '0;
            if (s4_den_reg[k][XW-1])
            begin
                s5_den_reg[k] <= -s4_den_reg[k];
                s5_nt_reg[k]  <= -s4_nt_reg[k];
                s5_ns_reg[k]  <= -s4_ns_reg[k];
            end
            else
            begin
                s5_den_reg[k] <= s4_den_reg[k];
                s5_nt_reg[k]  <= s4_nt_reg[k];
                s5_ns_reg[k]  <= s4_ns_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: range test of t and s, pick the first crossed edge
    // ------------------------------------------------------------------------
    function automatic logic in_unit(input logic signed [XW-1:0] n,
                                     input logic signed [XW-1:0] d);
        logic signed [SW-1:0] n_sh;
        logic signed [SW-1:0] d_ext;
        n_sh  = {n, {FRAC_W{1'b0}}};
        d_ext = SW'(d);
        return (n_sh >= d_ext) && (n <= d);
    endfunction

    logic         edge_ok [3];
    meta_t        sel_meta;
    logic [XW-1:0] sel_num, sel_den;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            edge_ok[k] = s5_nz_reg[k] && in_unit(s5_nt_reg[k], s5_den_reg[k])
                         && in_unit(s5_ns_reg[k], s5_den_reg[k]);
        sel_meta = '0;
        sel_num  = '0;
        sel_den  = '0;
        if (edge_ok[0])
        begin
            sel_meta = '{1'b1, s5_idx_reg[0], s5_idx_reg[1], EDGE_AB};
            sel_num  = s5_nt_reg[0];
            sel_den  = s5_den_reg[0];
        end
        else if (edge_ok[1])
        begin
            sel_meta = '{1'b1, s5_idx_reg[1], s5_idx_reg[2], EDGE_BC};
            sel_num  = s5_nt_reg[1];
            sel_den  = s5_den_reg[1];
        end
        else if (edge_ok[2])
        begin
            sel_meta = '{1'b1, s5_idx_reg[2], s5_idx_reg[0], EDGE_CA};
            sel_num  = s5_nt_reg[2];
            sel_den  = s5_den_reg[2];
        end
    end

    // ------------------------------------------------------------------------
    // Stages 6..: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------------
    logic               div_valid_reg [NSTP+1];
    meta_t              div_meta_reg  [NSTP+1];
    logic [RW-1:0]      div_rem_reg   [NSTP+1];
    logic [XW-1:0]      div_den_reg   [NSTP+1];
    logic [PARAM_W-1:0] div_quo_reg   [NSTP+1];

    logic [RW-1:0]      div_rem_next  [NSTP];
    logic [PARAM_W-1:0] div_quo_next  [NSTP];
    logic [RW-1:0]      div_trial     [NSTP];

    always_comb
    begin
        for (int j = 0; j < NSTP; j++)
        begin
            // first step compares n itself, later steps the doubled remainder
            div_trial[j] = (j == 0) ? div_rem_reg[j] : {div_rem_reg[j][RW-2:0], 1'b0};
            if (div_trial[j] >= RW'(div_den_reg[j]))
            begin
                div_rem_next[j] = div_trial[j] - RW'(div_den_reg[j]);
                div_quo_next[j] = {div_quo_reg[j][PARAM_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next[j] = div_trial[j];
                div_quo_next[j] = {div_quo_reg[j][PARAM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_meta_reg[0] <= sel_meta;
        div_rem_reg[0]  <= RW'(sel_num);
        div_den_reg[0]  <= sel_den;
        div_quo_reg[0]  <= '0;
        for (int j = 0; j < NSTP; j++)
        begin
            div_meta_reg[j+1] <= div_meta_reg[j];
            div_rem_reg[j+1]  <= div_rem_next[j];
            div_den_reg[j+1]  <= div_den_reg[j];
            div_quo_reg[j+1]  <= div_quo_next[j];
        end
    end

    // ------------------------------------------------------------------------
    // Valid bits travel with the data; loads drop out at entry
    // ------------------------------------------------------------------------
    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            for (int j = 0; j <= NSTP; j++)
                div_valid_reg[j] <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept && (cmd.action == ACT_QUERY);
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            div_valid_reg[0] <= s5_valid_reg;
            for (int j = 0; j < NSTP; j++)
                div_valid_reg[j+1] <= div_valid_reg[j];
            result_valid_reg <= div_valid_reg[NSTP];
        end
    end

    // Output register: a miss reads all zero.
    always_ff @(posedge clk)
    begin
        if (div_meta_reg[NSTP].hit)
            result_reg <= '{1'b1, div_meta_reg[NSTP].va, div_meta_reg[NSTP].vb,
                            div_meta_reg[NSTP].num, div_quo_reg[NSTP]};
        else
            result_reg <= '0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
